// File: hw/rtl/pffa_pkg.sv
// Shared constants, types and codes for the page first-fit allocator.
package pffa_pkg;

   localparam int NUM_PAGES  = 1024;
   localparam int PAGE_SHIFT = 12;
   localparam int IDX_W      = $clog2(NUM_PAGES);
   localparam int ALU_W      = IDX_W + 2;
   localparam int TAG_W      = ALU_W;
   localparam int PAGES_W    = $clog2(NUM_PAGES + 1);
   localparam int NEED_W     = 33 - PAGE_SHIFT;
   localparam int IDXF_W     = 32 - PAGE_SHIFT;

   localparam logic [31:0] HEAP_BASE_RESET = 32'h8000_0000;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
   localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef logic [IDX_W-1:0]        tag_addr_type;
   typedef logic signed [TAG_W-1:0] tag_type;

   typedef struct packed {
      logic         wr_en;
      tag_addr_type wr_addr;
      tag_type      wr_data;
      logic         rd_en;
      tag_addr_type rd_addr;
   } tag_ram_req_type;

   typedef enum logic [1:0] {
      ALU_C_ZERO,
      ALU_C_ONE,
      ALU_C_MINUS
   } alu_c_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_RD,
      S_CHK,
      S_AW_TAIL,
      S_AW_REM_HEAD,
      S_AW_REM_TAIL,
      S_FR_PREV,
      S_FR_PREV_CHK,
      S_FR_NEXT,
      S_FR_NEXT_CHK,
      S_FR_CLR_SETUP,
      S_FR_CLEAR,
      S_FR_FIRST,
      S_FR_LAST,
      S_EMIT
   } state_type;

endpackage

// File: hw/rtl/pffa_tag_ram.sv
// Boundary tag memory with one write port and one registered read port.
module pffa_tag_ram (
   input  logic                      clock,
   input  pffa_pkg::tag_ram_req_type req,
   output pffa_pkg::tag_type         rd_data
);
   import pffa_pkg::*;

   tag_type mem [NUM_PAGES];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule

// File: hw/rtl/page_first_fit_allocator_core.sv
// Top level of the page first-fit allocator with boundary tag coalescing.
//
// After reset the tag memory is initialised by a pass over the NUM_PAGES pages (1024 by default),
// one page a cycle, while req_stall is high; csr writes are taken throughout. Every item runs
// on a sequencer around one shared pointer adder and the tag memory, whose registered read
// port is separate from its write port; each block visited costs a read state and a check
// state, so the length of an item depends on the heap contents. An allocate reads the blocks
// up to and including the one that fits, writes the block's head and tail tags (and the head
// and tail tags of any remainder) and hands over the result; without a fit it reads every
// block in the heap. A free reads the blocks up to and including the freed one, reads its
// neighbours, sets up the clear, clears each interior page of the merged block, then writes
// the end tags and hands over the result. A free that misses a block head ends after its last
// block read. A zero size or an address outside the heap goes straight to the result.
// A result waits in the output register until its transfer completes, and the next result
// waits for it.
module page_first_fit_allocator_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [31:0]                   req_request_bytes,
   input  logic [31:0]                   req_block_address,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [31:0]                   rsp_result_address,
   output logic [pffa_pkg::PAGES_W-1:0]  rsp_pages_done,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [31:0]                   csr_heap_base
);
   import pffa_pkg::*;

   localparam logic [ALU_W-1:0] NUM_PAGES_A = ALU_W'(NUM_PAGES);
   localparam logic [ALU_W-1:0] LAST_PAGE_A = ALU_W'(NUM_PAGES - 1);
   localparam tag_type          INIT_TAG    = tag_type'(-NUM_PAGES);

   state_type            state_ff, state_in;
   logic                 kind_ff, kind_in;
   logic [ALU_W-1:0]     need_ff, need_in;
   logic                 need_big_ff, need_big_in;
   logic [ALU_W-1:0]     idx_ff, idx_in;
   logic [ALU_W-1:0]     i_ff, i_in;
   logic [ALU_W-1:0]     ptr_ff, ptr_in;
   logic [ALU_W-1:0]     have_ff, have_in;
   logic [ALU_W-1:0]     cnt_ff, cnt_in;
   logic [ALU_W-1:0]     first_ff, first_in;
   logic [ALU_W-1:0]     last_ff, last_in;
   tag_type              neg_total_ff, neg_total_in;
   logic [31:0]          res_addr_ff, res_addr_in;
   logic [PAGES_W-1:0]   res_pages_ff, res_pages_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [31:0]          heap_base_ff, heap_base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;
   logic [PAGES_W-1:0]   rsp_pages_ff, rsp_pages_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   tag_ram_req_type      ram_req;
   tag_type              ram_rd_data;

   logic [ALU_W-1:0]     alu_a, alu_b, alu_c_val, alu_sum;
   alu_c_type            alu_c;

   logic                 rd_neg;
   logic [ALU_W-1:0]     rd_mag, rd_step;
   logic                 alloc_hit;
   logic [ALU_W-1:0]     free_lim, free_cnt;
   tag_type              rem_neg_tag;
   logic                 at_idx;
   logic [NEED_W-1:0]    need_full;
   logic [31:0]          addr_off;
   logic                 idx_oob;
   logic                 rd_end;

   pffa_tag_ram u_tag_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (alu_c)
         ALU_C_ONE:   alu_c_val = ALU_W'(1);
         ALU_C_MINUS: alu_c_val = '1;
         default:     alu_c_val = '0;
      endcase
      alu_sum = alu_a + alu_b + alu_c_val;
   end

   always_comb begin
      rd_neg      = ram_rd_data[TAG_W-1];
      rd_mag      = rd_neg ? (~$unsigned(ram_rd_data) + 1'b1) : $unsigned(ram_rd_data);
      rd_step     = (ram_rd_data == '0) ? ALU_W'(1) : rd_mag;
      alloc_hit   = rd_neg && !need_big_ff && (rd_mag >= need_ff);
      free_lim    = NUM_PAGES_A - idx_ff;
      free_cnt    = (rd_mag > free_lim) ? free_lim : rd_mag;
      rem_neg_tag = $signed(need_ff - have_ff);
      at_idx      = (i_ff == idx_ff);
      need_full   = NEED_W'(req_request_bytes[31:PAGE_SHIFT])
                  + NEED_W'(|req_request_bytes[PAGE_SHIFT-1:0]);
      addr_off    = req_block_address - heap_base_ff;
      idx_oob     = addr_off[31:PAGE_SHIFT] >= IDXF_W'(NUM_PAGES);
      rd_end      = (kind_ff == KIND_ALLOC) ? (i_ff >= NUM_PAGES_A) : (i_ff > idx_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:         if (ptr_ff == LAST_PAGE_A) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_ALLOC) begin
                  state_in = (req_request_bytes == '0) ? S_EMIT : S_RD;
               end else begin
                  state_in = idx_oob ? S_EMIT : S_RD;
               end
            end
         end
         S_RD:           state_in = rd_end ? S_EMIT : S_CHK;
         S_CHK: begin
            if (kind_ff == KIND_ALLOC) begin
               state_in = alloc_hit ? S_AW_TAIL : S_RD;
            end else if (at_idx) begin
               state_in = (ram_rd_data > 0) ? S_FR_PREV : S_EMIT;
            end else begin
               state_in = S_RD;
            end
         end
         S_AW_TAIL:      state_in = (have_ff > need_ff) ? S_AW_REM_HEAD : S_EMIT;
         S_AW_REM_HEAD:  state_in = S_AW_REM_TAIL;
         S_AW_REM_TAIL:  state_in = S_EMIT;
         S_FR_PREV:      state_in = (idx_ff != '0) ? S_FR_PREV_CHK : S_FR_NEXT;
         S_FR_PREV_CHK:  state_in = S_FR_NEXT;
         S_FR_NEXT:      state_in = (alu_sum < NUM_PAGES_A) ? S_FR_NEXT_CHK : S_FR_CLR_SETUP;
         S_FR_NEXT_CHK:  state_in = S_FR_CLR_SETUP;
         S_FR_CLR_SETUP: state_in = S_FR_CLEAR;
         S_FR_CLEAR:     if (ptr_ff >= last_ff) state_in = S_FR_FIRST;
         S_FR_FIRST:     state_in = S_FR_LAST;
         S_FR_LAST:      state_in = S_EMIT;
         S_EMIT:         if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:        state_in = S_INIT;
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      need_in       = need_ff;
      need_big_in   = need_big_ff;
      idx_in        = idx_ff;
      i_in          = i_ff;
      ptr_in        = ptr_ff;
      have_in       = have_ff;
      cnt_in        = cnt_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      neg_total_in  = neg_total_ff;
      res_addr_in   = res_addr_ff;
      res_pages_in  = res_pages_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_status_in = rsp_status_ff;
      heap_base_in  = csr_valid ? csr_heap_base : heap_base_ff;
      ram_req       = '0;
      alu_a         = '0;
      alu_b         = '0;
      alu_c         = ALU_C_ZERO;

      case (state_ff)
         S_INIT: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff[IDX_W-1:0];
            ram_req.wr_data = (ptr_ff == '0 || ptr_ff == LAST_PAGE_A) ? INIT_TAG : '0;
            alu_a  = ptr_ff;
            alu_c  = ALU_C_ONE;
            ptr_in = alu_sum;
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in      = req_kind;
               i_in         = '0;
               need_in      = ALU_W'(need_full);
               need_big_in  = need_full > NEED_W'(NUM_PAGES);
               idx_in       = ALU_W'(addr_off[31:PAGE_SHIFT]);
               res_addr_in  = '0;
               res_pages_in = '0;
               res_status_in = (req_kind == KIND_ALLOC) ? STATUS_NO_SPACE : STATUS_NOT_ALLOC;
            end
         end
         S_RD: begin
            if (!rd_end) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = i_ff[IDX_W-1:0];
            end
         end
         S_CHK: begin
            alu_a = i_ff;
            alu_b = rd_step;
            if (kind_ff == KIND_ALLOC) begin
               if (alloc_hit) begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = i_ff[IDX_W-1:0];
                  ram_req.wr_data = $signed(need_ff);
                  alu_b         = need_ff;
                  alu_c         = ALU_C_MINUS;
                  ptr_in        = alu_sum;
                  have_in       = rd_mag;
                  res_addr_in   = heap_base_ff + (32'(i_ff) << PAGE_SHIFT);
                  res_pages_in  = PAGES_W'(need_ff);
                  res_status_in = STATUS_OK;
               end else begin
                  i_in = alu_sum;
               end
            end else if (at_idx) begin
               if (ram_rd_data > 0) begin
                  alu_a         = idx_ff;
                  alu_b         = free_cnt;
                  alu_c         = ALU_C_MINUS;
                  last_in       = alu_sum;
                  first_in      = idx_ff;
                  cnt_in        = free_cnt;
                  res_pages_in  = PAGES_W'(free_cnt);
                  res_status_in = STATUS_OK;
               end
            end else begin
               i_in = alu_sum;
            end
         end
         S_AW_TAIL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff[IDX_W-1:0];
            ram_req.wr_data = $signed(need_ff);
            alu_a  = i_ff;
            alu_b  = need_ff;
            ptr_in = alu_sum;
         end
         S_AW_REM_HEAD: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff[IDX_W-1:0];
            ram_req.wr_data = rem_neg_tag;
            alu_a  = i_ff;
            alu_b  = have_ff;
            alu_c  = ALU_C_MINUS;
            ptr_in = alu_sum;
         end
         S_AW_REM_TAIL: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = ptr_ff[IDX_W-1:0];
            ram_req.wr_data = rem_neg_tag;
         end
         S_FR_PREV: begin
            alu_a = idx_ff;
            alu_c = ALU_C_MINUS;
            if (idx_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = alu_sum[IDX_W-1:0];
            end
         end
         S_FR_PREV_CHK: begin
            alu_a = idx_ff;
            alu_b = ~rd_mag;
            alu_c = ALU_C_ONE;
            if (rd_neg) begin
               first_in = alu_sum[ALU_W-1] ? '0 : alu_sum;
            end
         end
         S_FR_NEXT: begin
            alu_a  = idx_ff;
            alu_b  = cnt_ff;
            ptr_in = alu_sum;
            if (alu_sum < NUM_PAGES_A) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = alu_sum[IDX_W-1:0];
            end
         end
         S_FR_NEXT_CHK: begin
            alu_a = ptr_ff;
            alu_b = rd_mag;
            alu_c = ALU_C_MINUS;
            if (rd_neg) begin
               last_in = (alu_sum < NUM_PAGES_A) ? alu_sum : LAST_PAGE_A;
            end
         end
         S_FR_CLR_SETUP: begin
            alu_a  = first_ff;
            alu_c  = ALU_C_ONE;
            ptr_in = alu_sum;
         end
         S_FR_CLEAR: begin
            alu_a = ptr_ff;
            alu_c = ALU_C_ONE;
            if (ptr_ff < last_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = ptr_ff[IDX_W-1:0];
               ram_req.wr_data = '0;
               ptr_in          = alu_sum;
            end
         end
         S_FR_FIRST: begin
            alu_a           = first_ff;
            alu_b           = ~last_ff;
            neg_total_in    = $signed(alu_sum);
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = first_ff[IDX_W-1:0];
            ram_req.wr_data = $signed(alu_sum);
         end
         S_FR_LAST: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = last_ff[IDX_W-1:0];
            ram_req.wr_data = neg_total_ff;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_pages_in  = res_pages_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         heap_base_ff <= HEAP_BASE_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         heap_base_ff <= heap_base_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      need_ff       <= need_in;
      need_big_ff   <= need_big_in;
      idx_ff        <= idx_in;
      i_ff          <= i_in;
      have_ff       <= have_in;
      cnt_ff        <= cnt_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      neg_total_ff  <= neg_total_in;
      res_addr_ff   <= res_addr_in;
      res_pages_ff  <= res_pages_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_pages_done     = rsp_pages_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: hw/rtl/pffa_checker.sv
// Port-level checker for the page first-fit allocator, bound to the top level.
module pffa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [31:0]                   rsp_result_address,
   input logic [pffa_pkg::PAGES_W-1:0]  rsp_pages_done,
   input logic [1:0]                    rsp_status
);
   import pffa_pkg::*;

   // A failed item carries neither an address nor a page count.
   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_result_address == '0 && rsp_pages_done == '0))
      else $error("failed result carries an address or page count");

   // A successful transfer always moves at least one page.
   a_ok_has_pages: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |-> (rsp_pages_done != '0))
      else $error("successful result with zero pages");

   // An accepted request moves the sequencer out of idle, so it stalls the next request.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted in consecutive cycles");

   // The tag memory is initialised after reset before any request is taken.
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_address)
         && $stable(rsp_pages_done) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind page_first_fit_allocator_core pffa_checker u_pffa_checker (.*);
